// ----- design/pli_pkg.sv -----
package pli_pkg;

   localparam int TableDepth        = 16;
   localparam int ValueWidthDefault = 32;
   localparam int CountWidth        = 5;
   localparam int IndexWidth        = 4;
   localparam logic [CountWidth-1:0] CountReset = 5'd2;

   localparam logic KindLoad  = 1'b0;
   localparam logic KindQuery = 1'b1;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_READ,
      BK_MUL,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage

// ----- design/piecewise_linear_interpolator.sv -----
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_stall | kind, point_index, x_value, y_value
// rsp     | out       | rsp_valid / rsp_stall | y_out, saturated
// csr     | in        | APB psel/penable      | point_count at 0x0
// Load: the entry is written once the request is accepted. Query: a table scan for
// segment k, then a multiply and a bit-serial division by the segment's x width.
// A two-entry query queue separates the front from the back; loads wait until the
// queue has drained and the back is idle.
// Reset is synchronous; the table holds no reset value.
module piecewise_linear_interpolator
   import pli_pkg::*;
#(
   parameter int VALUE_WIDTH = ValueWidthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_kind,
   input  logic [IndexWidth-1:0]  req_point_index,
   input  logic [VALUE_WIDTH-1:0] req_x_value,
   input  logic [VALUE_WIDTH-1:0] req_y_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VALUE_WIDTH-1:0] rsp_y_out,
   output logic                   rsp_saturated,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [1:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   logic [CountWidth-1:0]  count_ff;
   logic                   wr_en, q_valid, q_take, bk_busy;
   logic [IndexWidth-1:0]  wr_index;
   logic [VALUE_WIDTH-1:0] wr_x, wr_y, q_x;

   assign pready = 1'b1;
   assign prdata = (paddr == 2'd0) ? 32'(count_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CountReset;
      end else if (psel && penable && pwrite && paddr == 2'd0) begin
         count_ff <= pwdata[CountWidth-1:0];
      end
   end

   pli_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_stall(req_stall), .in_kind(req_kind),
      .in_index(req_point_index), .in_x(req_x_value), .in_y(req_y_value),
      .wr_en, .wr_index, .wr_x, .wr_y, .q_valid, .q_take, .bk_busy, .q_x
   );

   pli_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
      .clock, .reset, .point_count(count_ff),
      .wr_en, .wr_index, .wr_x, .wr_y, .q_valid, .q_take, .busy(bk_busy), .q_x,
      .out_valid(rsp_valid), .out_stall(rsp_stall),
      .out_y(rsp_y_out), .out_sat(rsp_saturated)
   );

endmodule

// ----- design/pli_front.sv -----
module pli_front
   import pli_pkg::*;
#(
   parameter int VALUE_WIDTH = ValueWidthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  logic                   in_kind,
   input  logic [IndexWidth-1:0]  in_index,
   input  logic [VALUE_WIDTH-1:0] in_x,
   input  logic [VALUE_WIDTH-1:0] in_y,
   output logic                   wr_en,
   output logic [IndexWidth-1:0]  wr_index,
   output logic [VALUE_WIDTH-1:0] wr_x,
   output logic [VALUE_WIDTH-1:0] wr_y,
   output logic                   q_valid,
   input  logic                   q_take,
   input  logic                   bk_busy,
   output logic [VALUE_WIDTH-1:0] q_x
);

   localparam int QDepth = 2;

   logic [VALUE_WIDTH-1:0] fifo_ff [QDepth];
   logic                   wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]             cnt_ff, cnt_in;
   logic                   push, pop, accept;

   // loads wait until queued and running queries are done, keeping table order
   assign in_stall = (cnt_ff == 2'(QDepth)) || (in_kind == KindLoad && cnt_ff != 2'd0) ||
                     (in_kind == KindLoad && (q_take || bk_busy));
   assign accept   = in_valid && !in_stall;
   assign push     = accept && in_kind == KindQuery;
   assign pop      = q_take && cnt_ff != 2'd0;

   assign wr_en    = accept && in_kind == KindLoad &&
                     ({1'b0, in_index} < (IndexWidth+1)'(TableDepth));
   assign wr_index = in_index;
   assign wr_x     = in_x;
   assign wr_y     = in_y;
   assign q_valid  = cnt_ff != 2'd0;
   assign q_x      = fifo_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         fifo_ff[wp_ff] <= in_x;
      end
   end

`ifndef SYNTHESIS
   a_cnt_max: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'(QDepth))
      else $error("queue overflow");
   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> cnt_ff == 2'd0 && !bk_busy)
      else $error("load while queries pending");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_take |-> q_valid)
      else $error("take from empty queue");
`endif

endmodule

// ----- design/pli_back.sv -----
module pli_back
   import pli_pkg::*;
#(
   parameter int VALUE_WIDTH = ValueWidthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [CountWidth-1:0]  point_count,
   input  logic                   wr_en,
   input  logic [IndexWidth-1:0]  wr_index,
   input  logic [VALUE_WIDTH-1:0] wr_x,
   input  logic [VALUE_WIDTH-1:0] wr_y,
   input  logic                   q_valid,
   output logic                   q_take,
   output logic                   busy,
   input  logic [VALUE_WIDTH-1:0] q_x,
   output logic                   out_valid,
   input  logic                   out_stall,
   output logic [VALUE_WIDTH-1:0] out_y,
   output logic                   out_sat
);

   localparam int AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
   localparam int KW = AW + 1;
   localparam int DW = VALUE_WIDTH + 1;
   localparam int PW = 2 * DW;
   localparam int PCW = $clog2(PW + 1);
   localparam int CW = VALUE_WIDTH + 3;

   logic [VALUE_WIDTH-1:0] mem_x [TableDepth];
   logic [VALUE_WIDTH-1:0] mem_y [TableDepth];

   back_state_type st_ff, st_in;
   logic [KW-1:0]          k_ff, k_in, n_lim;
   logic [VALUE_WIDTH-1:0] q_ff, q_in;
   logic [VALUE_WIDTH-1:0] rx_ff, ry_ff, px_ff, py_ff, px_in, py_in;
   logic [AW-1:0]          raddr;
   logic [PW-1:0]          num_ff, num_in;
   logic [DW-1:0]          rem_ff, rem_in, den_ff, den_in;
   logic [DW-1:0]          ma_ff, ma_in, mb_ff, mb_in;
   logic [PCW-1:0]         it_ff, it_in;
   logic                   neg_ff, neg_in;
   logic [VALUE_WIDTH-1:0] base_ff, base_in;
   logic [VALUE_WIDTH-1:0] y_ff, y_in;
   logic                   sat_ff, sat_in;
   logic                   ovalid_ff, ovalid_in;
   logic [DW:0]            trial;
   logic [DW-1:0]          rsh;
   logic signed [DW-1:0]   dy, dx, sp;
   logic signed [CW-1:0]   qv, sum;
   logic [PW-1:0]          qwide;

   always_comb begin
      if (point_count == '0) n_lim = KW'(1);
      else if ({1'b0, point_count} > (CountWidth+1)'(TableDepth)) n_lim = KW'(TableDepth);
      else n_lim = KW'(point_count);
   end

   assign raddr = k_in[AW-1:0];
   assign busy  = st_ff != BK_IDLE;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[wr_index[AW-1:0]] <= wr_x;
         mem_y[wr_index[AW-1:0]] <= wr_y;
      end
      rx_ff <= mem_x[raddr];
      ry_ff <= mem_y[raddr];
   end

   assign dy = DW'($signed(ry_ff)) - DW'($signed(py_ff));
   assign dx = DW'($signed(q_ff)) - DW'($signed(px_ff));
   assign sp = DW'($signed(rx_ff)) - DW'($signed(px_ff));
   assign rsh = {rem_ff[DW-2:0], num_ff[PW-1]};
   assign trial = {1'b0, rsh} - {1'b0, den_ff};
   assign qwide = num_ff;

   always_comb begin
      st_in = st_ff;
      k_in = k_ff;
      q_in = q_ff;
      px_in = px_ff;
      py_in = py_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      ma_in = ma_ff;
      mb_in = mb_ff;
      it_in = it_ff;
      neg_in = neg_ff;
      base_in = base_ff;
      y_in = y_ff;
      sat_in = sat_ff;
      ovalid_in = ovalid_ff && out_stall;
      q_take = 1'b0;
      qv = '0;
      sum = '0;
      case (st_ff)
         BK_IDLE: begin
            k_in = '0;
            if (q_valid && !ovalid_in) begin
               q_take = 1'b1;
               q_in = q_x;
               st_in = BK_READ;
            end
         end
         BK_READ: begin
            // rx/ry hold entry k
            if (k_ff == '0) begin
               px_in = rx_ff;
               py_in = ry_ff;
               if ($signed(q_ff) < $signed(rx_ff)) begin
                  y_in = ry_ff;
                  sat_in = 1'b0;
                  st_in = BK_DONE;
               end else if (n_lim == KW'(1)) begin
                  y_in = ry_ff;
                  sat_in = 1'b0;
                  st_in = BK_DONE;
               end else begin
                  k_in = KW'(1);
                  st_in = BK_SCAN;
               end
            end else if ($signed(q_ff) <= $signed(rx_ff)) begin
               base_in = py_ff;
               if (sp == '0) begin
                  y_in = py_ff;
                  sat_in = 1'b0;
                  st_in = BK_DONE;
               end else begin
                  neg_in = (dy[DW-1] != dx[DW-1]) != sp[DW-1];
                  ma_in = dy[DW-1] ? DW'(-dy) : DW'(dy);
                  mb_in = dx[DW-1] ? DW'(-dx) : DW'(dx);
                  den_in = sp[DW-1] ? DW'(-sp) : DW'(sp);
                  st_in = BK_MUL;
               end
            end else begin
               px_in = rx_ff;
               py_in = ry_ff;
               if (k_ff + KW'(1) >= n_lim) begin
                  y_in = ry_ff;
                  sat_in = 1'b0;
                  st_in = BK_DONE;
               end else begin
                  k_in = k_ff + KW'(1);
                  st_in = BK_SCAN;
               end
            end
         end
         BK_SCAN: st_in = BK_READ;
         BK_MUL: begin
            num_in = PW'(ma_ff) * PW'(mb_ff);
            rem_in = '0;
            it_in = PCW'(PW);
            st_in = BK_DIV;
         end
         BK_DIV: begin
            if (it_ff != '0) begin
               num_in = {num_ff[PW-2:0], ~trial[DW]};
               rem_in = trial[DW] ? rsh : trial[DW-1:0];
               it_in = it_ff - PCW'(1);
            end else begin
               if (qwide > PW'(1) << (VALUE_WIDTH + 1)) qv = CW'(1) <<< (VALUE_WIDTH + 1);
               else qv = CW'(qwide);
               sum = neg_ff ? CW'($signed(base_ff)) - qv : CW'($signed(base_ff)) + qv;
               if (sum > CW'((CW'(1) <<< (VALUE_WIDTH - 1)) - CW'(1))) begin
                  y_in = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
                  sat_in = 1'b1;
               end else if (sum < -(CW'(1) <<< (VALUE_WIDTH - 1))) begin
                  y_in = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
                  sat_in = 1'b1;
               end else begin
                  y_in = sum[VALUE_WIDTH-1:0];
                  sat_in = 1'b0;
               end
               st_in = BK_DONE;
            end
         end
         BK_DONE: begin
            ovalid_in = 1'b1;
            st_in = BK_IDLE;
         end
         default: st_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BK_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ovalid_ff <= ovalid_in;
      end
      k_ff <= k_in;
      q_ff <= q_in;
      px_ff <= px_in;
      py_ff <= py_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      it_ff <= it_in;
      neg_ff <= neg_in;
      base_ff <= base_in;
      y_ff <= y_in;
      sat_ff <= sat_in;
   end

   assign out_valid = ovalid_ff;
   assign out_y = y_ff;
   assign out_sat = sat_ff;

`ifndef SYNTHESIS
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      q_take |-> st_ff == BK_IDLE && !(ovalid_ff && out_stall))
      else $error("take while busy");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      st_ff == BK_DONE |=> out_valid)
      else $error("result lost");
   a_div_den: assert property (@(posedge clock) disable iff (reset)
      st_ff == BK_DIV |-> den_ff != '0)
      else $error("zero divisor");
`endif

endmodule
